// ===== rtl/e2q_pkg.sv =====
package e2q_pkg;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_t;

  localparam int CORDIC_STEPS = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
  // reduce + cordic stages + round, then pair product, triple product, sum
  localparam int SC_LAT = CORDIC_STAGES + 2;
  localparam int PIPE_LAT = SC_LAT + 3;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [20:0] Q14_ONE     = 21'sd16384;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/e2q_sincos.sv =====
module e2q_sincos (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output logic signed [17:0] sin_q16,
  output logic signed [17:0] cos_q16
);

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic               flip;
  } cs_t;

  function automatic cs_t rot(input cs_t a, input int unsigned i);
    cs_t r;
    r = a;
    if (!a.z[31]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - $signed(e2q_pkg::atan_q30(5'(i)));
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + $signed(e2q_pkg::atan_q30(5'(i)));
    end
    return r;
  endfunction

  // all rotations that one register stage holds
  function automatic cs_t stage(input cs_t a, input int unsigned k);
    cs_t r;
    r = a;
    for (int unsigned j = 0; j < e2q_pkg::STEPS_PER_STAGE; j++) begin
      r = rot(r, k * e2q_pkg::STEPS_PER_STAGE + j);
    end
    return r;
  endfunction

  cs_t st_r [0:e2q_pkg::CORDIC_STAGES];
  cs_t st0_nxt;
  logic signed [33:0] z_full;
  logic signed [33:0] z_red;
  logic signed [32:0] xf;
  logic signed [32:0] yf;
  logic signed [17:0] sin_r;
  logic signed [17:0] cos_r;

  // half angle: Q3.13 code read as Q2.14, held in Q30
  always_comb begin
    z_full = {{2{angle[15]}}, angle, 16'b0};
    st0_nxt.flip = 1'b0;
    z_red = z_full;
    if (z_full > e2q_pkg::HALF_PI_Q30) begin
      z_red = z_full - e2q_pkg::PI_Q30;
      st0_nxt.flip = 1'b1;
    end else if (z_full < -e2q_pkg::HALF_PI_Q30) begin
      z_red = z_full + e2q_pkg::PI_Q30;
      st0_nxt.flip = 1'b1;
    end
    st0_nxt.z = z_red[31:0];
    st0_nxt.x = e2q_pkg::GAIN_Q30;
    st0_nxt.y = '0;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  for (genvar k = 0; k < e2q_pkg::CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      st_r[k+1] <= stage(st_r[k], k);
    end
  end

  always_comb begin
    xf = st_r[e2q_pkg::CORDIC_STAGES].flip ? -st_r[e2q_pkg::CORDIC_STAGES].x
                                           : st_r[e2q_pkg::CORDIC_STAGES].x;
    yf = st_r[e2q_pkg::CORDIC_STAGES].flip ? -st_r[e2q_pkg::CORDIC_STAGES].y
                                           : st_r[e2q_pkg::CORDIC_STAGES].y;
  end

  always_ff @(posedge clk) begin
    cos_r <= 18'((xf + 33'sd8192) >>> 14);
    sin_r <= 18'((yf + 33'sd8192) >>> 14);
  end

  assign sin_q16 = sin_r;
  assign cos_q16 = cos_r;

endmodule

// ===== rtl/euler_to_quaternion.sv =====
// ZYX Euler angles to unit quaternion, fully pipelined.
// Registers from input to result, in order: reduce, 12 CORDIC stages of two rotations each,
// round, two multiply stages, sum; out_valid rises together with the result.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// Reset clears only the valid pipeline; data registers are not reset.
module euler_to_quaternion (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  e2q_pkg::in_t  in_data,
  output logic          out_valid,
  output e2q_pkg::out_t out_data
);

  logic [e2q_pkg::PIPE_LAT-1:0] vld_r;
  logic [e2q_pkg::PIPE_LAT-1:0] vld_nxt;
  logic accept;

  logic signed [17:0] sy, cy, sp, cp, sr, cr;
  logic signed [35:0] cc_r, ss_r, cs_r, sc_r;
  logic signed [17:0] sr_r, cr_r;
  logic signed [53:0] t_ccr_r, t_sss_r, t_ccs_r, t_ssc_r;
  logic signed [53:0] t_csc_r, t_scs_r, t_scc_r, t_css_r;
  e2q_pkg::out_t out_r;
  e2q_pkg::out_t out_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  e2q_sincos u_yaw   (.clk(clk), .angle(in_data.yaw_angle),   .sin_q16(sy), .cos_q16(cy));
  e2q_sincos u_pitch (.clk(clk), .angle(in_data.pitch_angle), .sin_q16(sp), .cos_q16(cp));
  e2q_sincos u_roll  (.clk(clk), .angle(in_data.roll_angle),  .sin_q16(sr), .cos_q16(cr));

  always_comb begin
    vld_nxt = {vld_r[e2q_pkg::PIPE_LAT-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // yaw-pitch pairs, roll carried alongside
  always_ff @(posedge clk) begin
    cc_r <= cy * cp;
    ss_r <= sy * sp;
    cs_r <= cy * sp;
    sc_r <= sy * cp;
    sr_r <= sr;
    cr_r <= cr;
  end

  always_ff @(posedge clk) begin
    t_ccr_r <= cc_r * cr_r;
    t_sss_r <= ss_r * sr_r;
    t_ccs_r <= cc_r * sr_r;
    t_ssc_r <= ss_r * cr_r;
    t_csc_r <= cs_r * cr_r;
    t_scs_r <= sc_r * sr_r;
    t_scc_r <= sc_r * cr_r;
    t_css_r <= cs_r * sr_r;
  end

  function automatic logic signed [15:0] to_q14(input logic signed [54:0] s);
    logic signed [54:0] rs;
    logic signed [20:0] r;
    rs = (s + (55'sd1 <<< 33)) >>> 34;
    r  = rs[20:0];
    if (r > e2q_pkg::Q14_ONE) begin
      r = e2q_pkg::Q14_ONE;
    end else if (r < -e2q_pkg::Q14_ONE) begin
      r = -e2q_pkg::Q14_ONE;
    end
    return r[15:0];
  endfunction

  always_comb begin
    out_nxt.quat_w = to_q14(55'(t_ccr_r) + 55'(t_sss_r));
    out_nxt.quat_x = to_q14(55'(t_ccs_r) - 55'(t_ssc_r));
    out_nxt.quat_y = to_q14(55'(t_csc_r) + 55'(t_scs_r));
    out_nxt.quat_z = to_q14(55'(t_scc_r) - 55'(t_css_r));
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[e2q_pkg::PIPE_LAT-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##17 out_valid)
    else $error("item lost in pipeline");

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_range_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384 &&
                   out_data.quat_x <= 16'sd16384 && out_data.quat_x >= -16'sd16384))
    else $error("w/x out of range");

  a_range_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_y <= 16'sd16384 && out_data.quat_y >= -16'sd16384 &&
                   out_data.quat_z <= 16'sd16384 && out_data.quat_z >= -16'sd16384))
    else $error("y/z out of range");
`endif

endmodule

// ===== test/euler_to_quaternion_check.sv =====
`timescale 1ns / 1ps

module euler_to_quaternion_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  e2q_pkg::in_t  in_data,
  input  logic          out_valid,
  input  e2q_pkg::out_t out_data,
  output int            n_errors,
  output int            n_pending
);

  localparam longint PI_HALFTURN = 64'sd3373259426;
  localparam longint PI_QUARTER  = 64'sd1686629713;
  localparam longint CORDIC_K    = 64'sd652032874;

  e2q_pkg::out_t quat_queue[$];

  function automatic longint arctan_step(input int i);
    case (i)
      0: return 64'h3243F6A8;  1: return 64'h1DAC6705;  2: return 64'h0FADBAFC;
      3: return 64'h07F56EA6;  4: return 64'h03FEAB76;  5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;  7: return 64'h007FFF55;  8: return 64'h003FFFEA;
      9: return 64'h001FFFFD;  10: return 64'h000FFFFF; 11: return 64'h0007FFFF;
      12: return 64'h0003FFFF; 13: return 64'h0001FFFF; 14: return 64'h0000FFFF;
      15: return 64'h00007FFF; 16: return 64'h00003FFF; 17: return 64'h00001FFF;
      18: return 64'h00000FFF; 19: return 64'h000007FF; 20: return 64'h000003FF;
      21: return 64'h000001FF; 22: return 64'h000000FF; default: return 64'h0000007F;
    endcase
  endfunction

  // half-angle sine and cosine in Q16
  function automatic void half_angle_sincos(input logic signed [15:0] code,
                                            output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = longint'(code) * 65536;
    x = CORDIC_K;
    y = 0;
    flip = 0;
    if (z > PI_QUARTER) begin
      z -= PI_HALFTURN;
      flip = 1;
    end else if (z < -PI_QUARTER) begin
      z += PI_HALFTURN;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = (x + 8192) >>> 14;
    sn = (y + 8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] round_q14(input longint s);
    longint r;
    r = (s + (64'sd1 <<< 33)) >>> 34;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic e2q_pkg::out_t quaternion_of(input e2q_pkg::in_t a);
    longint sy, cy, sp, cp, sr, cr;
    e2q_pkg::out_t q;
    half_angle_sincos(a.yaw_angle, sy, cy);
    half_angle_sincos(a.pitch_angle, sp, cp);
    half_angle_sincos(a.roll_angle, sr, cr);
    q.quat_w = round_q14(cy * cp * cr + sy * sp * sr);
    q.quat_x = round_q14(cy * cp * sr - sy * sp * cr);
    q.quat_y = round_q14(cy * sp * cr + sy * cp * sr);
    q.quat_z = round_q14(sy * cp * cr - cy * sp * sr);
    return q;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  initial n_errors = 0;
  assign n_pending = quat_queue.size();

  always @(posedge clk) begin
    e2q_pkg::out_t want;
    if (rst_n && start && !busy) quat_queue.push_back(quaternion_of(in_data));
    if (rst_n && out_valid) begin
      if (quat_queue.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        want = quat_queue.pop_front();
        if (out_data.quat_w !== want.quat_w) report("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.quat_x !== want.quat_x) report("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y) report("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z) report("quat_z", out_data.quat_z, want.quat_z);
      end
    end
  end
endmodule

// ===== test/euler_to_quaternion_test.sv =====
`timescale 1ns / 1ps

module euler_to_quaternion_test;

  localparam int WATCHDOG = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy, out_valid;
  e2q_pkg::in_t in_data = '0;
  e2q_pkg::out_t out_data;
  int n_errors, n_pending;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  euler_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  euler_to_quaternion_check chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .n_errors(n_errors), .n_pending(n_pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("euler_to_quaternion_test: errors");
      $finish;
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h8000 + 16'($urandom_range(0, 40));
      1: return 16'h7FFF - 16'($urandom_range(0, 40));
      2: return 16'($signed($urandom_range(0, 400)) - 200);
      3: return 16'd25736 + 16'($urandom_range(0, 20)) - 16'd10; // half-turn reduction edge
      4: return 16'd0 - 16'd25736 + 16'($urandom_range(0, 20)) - 16'd10;
      default: return 16'($urandom);
    endcase
  endfunction

  // one item offered, with a random gap first when gaps is set; held until accepted
  task automatic send_item(input e2q_pkg::in_t a, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_data <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    e2q_pkg::in_t a;
    logic [15:0] corner [9];
    corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
               16'd25736, -16'sd25736, 16'd25737, 16'h5555};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 9; i++) begin
      a.yaw_angle = corner[i];
      a.pitch_angle = corner[(i + 3) % 9];
      a.roll_angle = corner[(i + 6) % 9];
      send_item(a, 0);
    end
    for (int i = 0; i < 9; i++) begin
      a = '{corner[i], corner[i], corner[i]};
      send_item(a, 0);
    end
    start <= 0;
    // let the pipeline drain once before the random part
    while (n_pending != 0) @(posedge clk);
    for (int n = 0; n < 850; n++) begin
      a.yaw_angle = pick_angle();
      a.pitch_angle = pick_angle();
      a.roll_angle = pick_angle();
      send_item(a, (n / 200) % 2 == 0);
    end
    start <= 0;
    while (n_pending != 0) @(posedge clk);
    repeat (e2q_pkg::PIPE_LAT + 5) @(posedge clk);
    if (n_errors == 0 && n_pending == 0)
      $display("euler_to_quaternion_test: clean");
    else
      $display("euler_to_quaternion_test: errors");
    $finish;
  end
endmodule
